// ===== design/lppd_pkg.sv =====
package lppd_pkg;

	localparam logic [7:0] TYPE_SHORT_A = 8'hC1;
	localparam logic [7:0] TYPE_SHORT_B = 8'hC3;
	localparam logic [7:0] TYPE_LONG_A  = 8'hC2;
	localparam logic [7:0] TYPE_LONG_B  = 8'hC4;
	localparam logic [7:0] HEAD_PLAIN_A = 8'h04;
	localparam logic [7:0] HEAD_PLAIN_B = 8'h05;

	localparam int unsigned MIN_LEN_SHORT = 3;
	localparam int unsigned MIN_LEN_LONG  = 4;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_HEADER = 2'd1,
		ERR_LENGTH = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_first;
		logic       frame_last;
		logic [1:0] error_code;
	} out_item_t;

	typedef struct packed {
		logic      emit;
		out_item_t item;
	} res_t;

endpackage

// ===== design/lppd_stream_if.sv =====
interface lppd_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lppd_frame_fsm.sv =====
module lppd_frame_fsm #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lppd_pkg::in_item_t item,
	input  logic [7:0]        xor_key,
	output lppd_pkg::res_t    res
);
	import lppd_pkg::*;

	typedef enum logic [5:0] {
		S_TYPE   = 6'b000001,
		S_LEN_HI = 6'b000010,
		S_LEN_LO = 6'b000100,
		S_HEAD   = 6'b001000,
		S_BODY   = 6'b010000,
		S_ERROR  = 6'b100000
	} state_t;

	state_t                 state_q, state_d, st;
	logic [LENGTH_BITS-1:0] pos_q, pos_d, pos, len_q, len_d, len_new;
	logic [7:0]             hi_q, hi_d, b;
	logic                   long_q, long_d, last;
	logic [LENGTH_BITS:0]   pos_inc;

	always_comb begin
		st      = item.restart ? S_TYPE : state_q;
		pos     = item.restart ? '0 : pos_q;
		b       = item.in_byte;
		pos_inc = {1'b0, pos} + {{LENGTH_BITS{1'b0}}, 1'b1};
		last    = pos_inc >= {1'b0, len_q};
		len_new = LENGTH_BITS'({hi_q, b});

		state_d = st;
		pos_d   = pos;
		len_d   = len_q;
		hi_d    = hi_q;
		long_d  = long_q;
		res     = '0;
		res.item.out_byte   = b;
		res.item.error_code = ERR_NONE;

		case (st)
			S_TYPE: begin
				res.emit = 1'b1;
				if (b inside {TYPE_SHORT_A, TYPE_SHORT_B, TYPE_LONG_A, TYPE_LONG_B}) begin
					res.item.frame_first = 1'b1;
					long_d  = b inside {TYPE_LONG_A, TYPE_LONG_B};
					state_d = long_d ? S_LEN_HI : S_LEN_LO;
					hi_d    = '0;
					len_d   = '0;
					pos_d   = LENGTH_BITS'(1);
				end else begin
					res.item.error_code = ERR_HEADER;
					state_d = S_ERROR;
					pos_d   = '0;
				end
			end
			S_LEN_HI: begin
				res.emit = 1'b1;
				hi_d     = b;
				pos_d    = pos_inc[LENGTH_BITS-1:0];
				state_d  = S_LEN_LO;
			end
			S_LEN_LO: begin
				res.emit = 1'b1;
				len_d    = len_new;
				if (len_new < (long_q ? LENGTH_BITS'(MIN_LEN_LONG)
				                      : LENGTH_BITS'(MIN_LEN_SHORT))) begin
					res.item.error_code = ERR_LENGTH;
					state_d = S_ERROR;
					pos_d   = '0;
				end else begin
					pos_d   = pos_inc[LENGTH_BITS-1:0];
					state_d = S_HEAD;
				end
			end
			S_HEAD, S_BODY: begin
				res.emit = 1'b1;
				if (st == S_HEAD && !(b inside {HEAD_PLAIN_A, HEAD_PLAIN_B})) begin
					res.item.out_byte = b ^ xor_key;
				end
				res.item.frame_last = last;
				pos_d   = last ? '0 : pos_inc[LENGTH_BITS-1:0];
				state_d = last ? S_TYPE : S_BODY;
			end
			S_ERROR: begin
				res.emit = 1'b0;
			end
			default: begin
				state_d = S_TYPE;
				pos_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TYPE;
			pos_q   <= '0;
			len_q   <= '0;
			hi_q    <= '0;
			long_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			hi_q    <= hi_d;
			long_q  <= long_d;
		end
	end

endmodule

// ===== design/length_prefixed_packet_deframer.sv =====
// Channel   Direction  Payload
// in_ch     sink       in_byte[7:0], restart
// out_ch    source     out_byte[7:0], frame_first, frame_last, error_code[1:0]
// cfg       write      cfg_wr_en, cfg_wr_data[7:0] (xor_key)
//
// One byte is taken in every cycle with in_ch.ready high; its result shows in
// the next cycle from the output register, and a dropped byte gives no result.
// The frame state advances in the cycle of the transfer, so a new byte may
// follow at once. Reset clears the frame state, the key and the output valid.
// While a result waits, in_ch.ready stays high only if out_ch.ready takes it.
module length_prefixed_packet_deframer #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lppd_stream_if.sink   in_ch,
	lppd_stream_if.source out_ch,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data
);
	import lppd_pkg::*;

	logic       accept;
	logic [7:0] xor_key_q;
	logic       out_valid_q;
	out_item_t  out_q;
	res_t       res;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	lppd_frame_fsm #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.item(in_ch.data),
		.xor_key(xor_key_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q <= '0;
		end else if (cfg_wr_en) begin
			xor_key_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept ? res.emit : (out_valid_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.emit) begin
			out_q <= res.item;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

// ===== design/lppd_checker.sv =====
module lppd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lppd_pkg::out_item_t out_data
);
	import lppd_pkg::*;

	a_rise_needs_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("Result appeared without an input transfer.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled result changed.");

	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_first |->
			out_data.error_code == ERR_NONE && !out_data.frame_last)
		else $error("Frame start carries an error or a last mark.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the output register is empty.");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);

// ===== test/length_prefixed_packet_deframer_tb.sv =====
`timescale 1ns / 100ps

module length_prefixed_packet_deframer_tb;
	import lppd_pkg::*;

	localparam int unsigned LEN_BITS = 16;
	localparam logic [15:0] LEN_MASK = 16'((32'd1 << LEN_BITS) - 1);
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RESULTS_PER_PHASE = 105;

	typedef enum logic [1:0] {
		ROW_CHECKED,
		ROW_PINNED,
		ROW_KEY
	} row_kind_t;

	typedef struct packed {
		logic      pinned;
		logic      emit;
		out_item_t item;
	} pin_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] val;
		logic       rst;
		logic       emit;
		out_item_t  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	lppd_stream_if #(.T(in_item_t))  in_ch ();
	lppd_stream_if #(.T(out_item_t)) out_ch ();

	length_prefixed_packet_deframer #(.LENGTH_BITS(LEN_BITS)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #1 clk = ~clk;

	// Deframer state as predicted from the accepted bytes.
	logic [15:0] frm_pos = '0;
	logic [15:0] frm_len = '0;
	logic        frm_long = 1'b0;
	logic        frm_err = 1'b0;
	logic [7:0]  head_key = '0;

	out_item_t   pending_bytes[$];
	pin_t        pinned_results[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	logic        need_restart = 1'b1;

	stim_row_t dir_rows [25] = '{
		'{ROW_PINNED,  8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, ERR_HEADER}},
		'{ROW_PINNED,  8'hFF, 1'b0, 1'b0, '0},
		'{ROW_PINNED,  8'hC1, 1'b1, 1'b1, {8'hC1, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_PINNED,  8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, ERR_LENGTH}},
		'{ROW_PINNED,  8'hC3, 1'b1, 1'b1, {8'hC3, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_PINNED,  8'h02, 1'b0, 1'b1, {8'h02, 1'b0, 1'b0, ERR_LENGTH}},
		'{ROW_PINNED,  8'hC2, 1'b1, 1'b1, {8'hC2, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_CHECKED, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PINNED,  8'h03, 1'b0, 1'b1, {8'h03, 1'b0, 1'b0, ERR_LENGTH}},
		'{ROW_PINNED,  8'hC4, 1'b1, 1'b1, {8'hC4, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_CHECKED, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h04, 1'b0, 1'b0, '0},
		'{ROW_PINNED,  8'h80, 1'b1, 1'b1, {8'h80, 1'b0, 1'b0, ERR_HEADER}},
		'{ROW_KEY,     8'hFF, 1'b0, 1'b0, '0},
		'{ROW_PINNED,  8'hC1, 1'b1, 1'b1, {8'hC1, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_CHECKED, 8'h04, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h3C, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_PINNED,  8'hC3, 1'b0, 1'b1, {8'hC3, 1'b1, 1'b0, ERR_NONE}},
		'{ROW_CHECKED, 8'h03, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h04, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'hC1, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h03, 1'b0, 1'b0, '0},
		'{ROW_CHECKED, 8'h05, 1'b0, 1'b0, '0}
	};

	function automatic void deframe_step(input in_item_t it, output logic emit,
		output out_item_t res);
		logic [7:0]  b;
		logic [15:0] head_pos;
		logic [15:0] min_len;
		b = it.in_byte;
		emit = 1'b1;
		res = '0;
		res.out_byte = b;
		res.error_code = ERR_NONE;
		head_pos = frm_long ? 16'd3 : 16'd2;
		min_len = frm_long ? 16'(MIN_LEN_LONG) : 16'(MIN_LEN_SHORT);
		if (it.restart) begin
			frm_err = 1'b0;
			frm_pos = '0;
		end
		if (frm_err) begin
			emit = 1'b0;
		end else if (frm_pos == 16'd0) begin
			if (b == TYPE_SHORT_A || b == TYPE_SHORT_B || b == TYPE_LONG_A ||
				b == TYPE_LONG_B) begin
				frm_long = (b == TYPE_LONG_A || b == TYPE_LONG_B);
				frm_len = '0;
				frm_pos = 16'd1;
				res.frame_first = 1'b1;
			end else begin
				frm_err = 1'b1;
				res.error_code = ERR_HEADER;
			end
		end else if (frm_pos < head_pos) begin
			if (frm_long && frm_pos == 16'd1) begin
				frm_len = {b, 8'h00};
				frm_pos = 16'd2;
			end else begin
				frm_len = (frm_len | {8'h00, b}) & LEN_MASK;
				if (frm_len == 16'd0 || frm_len < min_len) begin
					frm_err = 1'b1;
					frm_pos = '0;
					res.error_code = ERR_LENGTH;
				end else begin
					frm_pos = frm_pos + 16'd1;
				end
			end
		end else begin
			if (frm_pos == head_pos && head_key != 8'h00 && b != HEAD_PLAIN_A &&
				b != HEAD_PLAIN_B) begin
				res.out_byte = b ^ head_key;
			end
			if ({1'b0, frm_pos} + 17'd1 >= {1'b0, frm_len}) begin
				res.frame_last = 1'b1;
				frm_pos = '0;
			end else begin
				frm_pos = frm_pos + 16'd1;
			end
		end
	endfunction

	always @(posedge clk) begin
		logic      emit;
		out_item_t res;
		out_item_t want;
		pin_t      pin;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL length_prefixed_packet_deframer");
			$finish;
		end
		if (cfg_wr_en) begin
			head_key = cfg_wr_data;
		end
		if (in_ch.valid && in_ch.ready) begin
			deframe_step(in_ch.data, emit, res);
			pin = pinned_results.pop_front();
			if (pin.pinned) begin
				emit = pin.emit;
				res = pin.item;
			end
			if (emit) begin
				pending_bytes.push_back(res);
			end
		end
		if (out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, out_byte %02h", $time,
					out_ch.data.out_byte);
			end else begin
				want = pending_bytes.pop_front();
				if (want.out_byte !== out_ch.data.out_byte) begin
					mismatches++;
					$display("%0t: out_byte expected %02h actual %02h", $time,
						want.out_byte, out_ch.data.out_byte);
				end
				if (want.frame_first !== out_ch.data.frame_first) begin
					mismatches++;
					$display("%0t: frame_first expected %0b actual %0b", $time,
						want.frame_first, out_ch.data.frame_first);
				end
				if (want.frame_last !== out_ch.data.frame_last) begin
					mismatches++;
					$display("%0t: frame_last expected %0b actual %0b", $time,
						want.frame_last, out_ch.data.frame_last);
				end
				if (want.error_code !== out_ch.data.error_code) begin
					mismatches++;
					$display("%0t: error_code expected %0d actual %0d", $time,
						want.error_code, out_ch.data.error_code);
				end
			end
		end
	end

	task automatic send_byte(input in_item_t it, input pin_t pin);
		@(negedge clk);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 12);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		pinned_results.push_back(pin);
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_key(input logic [7:0] k);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= k;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_frame();
		int unsigned kind;
		int unsigned flen;
		int unsigned cut;
		logic [7:0]  ftype;
		logic [7:0]  head;
		logic [7:0]  b;
		logic        is_long;
		logic        rst;
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			send_byte({8'($urandom), $urandom_range(0, 3) == 0}, '0);
			need_restart = 1'b1;
			return;
		end
		case ($urandom_range(0, 3))
			0: ftype = TYPE_SHORT_A;
			1: ftype = TYPE_SHORT_B;
			2: ftype = TYPE_LONG_A;
			default: ftype = TYPE_LONG_B;
		endcase
		is_long = (ftype == TYPE_LONG_A || ftype == TYPE_LONG_B);
		rst = need_restart || ($urandom_range(0, 3) == 0);
		if (kind < 4) begin
			send_byte({ftype, rst}, '0);
			if (is_long) begin
				send_byte({8'h00, 1'b0}, '0);
				send_byte({8'($urandom_range(0, 3)), 1'b0}, '0);
			end else begin
				send_byte({8'($urandom_range(0, 2)), 1'b0}, '0);
			end
			need_restart = 1'b1;
			return;
		end
		if (is_long) begin
			flen = ($urandom_range(0, 63) == 0) ? $urandom_range(256, 320) :
				$urandom_range(4, 14);
		end else begin
			flen = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) :
				$urandom_range(3, 10);
		end
		cut = (kind == 4) ? $urandom_range(1, flen - 1) : flen;
		case ($urandom_range(0, 3))
			0: head = HEAD_PLAIN_A;
			1: head = HEAD_PLAIN_B;
			default: head = 8'($urandom);
		endcase
		for (int unsigned i = 0; i < cut; i++) begin
			if (i == 0) begin
				b = ftype;
			end else if (is_long && i == 1) begin
				b = flen[15:8];
			end else if (i == (is_long ? 2 : 1)) begin
				b = flen[7:0];
			end else if (i == (is_long ? 3 : 2)) begin
				b = head;
			end else begin
				b = 8'($urandom);
			end
			send_byte({b, (i == 0) ? rst : 1'b0}, '0);
		end
		need_restart = (cut != flen);
	endtask

	initial begin
		logic [7:0]  phase_keys [6];
		int unsigned target;
		phase_keys = '{8'h01, 8'h80, 8'($urandom_range(2, 254)), 8'h00,
			8'($urandom_range(1, 255)), 8'hFF};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		fork
			begin : sink_stalls
				logic [15:0] stall_pat;
				int unsigned stall_cnt;
				stall_pat = '1;
				stall_cnt = 0;
				forever begin
					@(negedge clk);
					stall_cnt++;
					if (stall_cnt % 64 == 0) begin
						stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
					end
					out_ch.ready <= stall_pat[stall_cnt % 16];
				end
			end
		join_none
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_KEY) begin
				load_key(dir_rows[r].val);
			end else begin
				send_byte({dir_rows[r].val, dir_rows[r].rst},
					{dir_rows[r].kind == ROW_PINNED, dir_rows[r].emit, dir_rows[r].want});
			end
		end

		foreach (phase_keys[p]) begin
			load_key(phase_keys[p]);
			target = results_seen + RESULTS_PER_PHASE;
			while (results_seen < target) begin
				send_frame();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("PASS length_prefixed_packet_deframer");
		end else begin
			$display("FAIL length_prefixed_packet_deframer");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/lppd_pkg.sv
design/lppd_stream_if.sv
design/lppd_frame_fsm.sv
design/length_prefixed_packet_deframer.sv
design/lppd_checker.sv
test/length_prefixed_packet_deframer_tb.sv
